@@ rtl/rgbhsl_pkg.sv @@
// Package for the RGB to HSL converter.
// Holds default parameter values and port field widths; no dependencies.
package rgbhsl_pkg;
	localparam int COMP_BITS_DEF = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_W = 8;
	localparam int OUT_W = 16;
endpackage

@@ rtl/rgb_to_hsl_converter_top.sv @@
// RGB to HSL converter, one pixel per clock sustained.
// After the queue a pixel passes the divider entry register,
// FRAC_BITS+1 one-bit divider stages and the saturation register before done rises.
// Throughput: one pixel per cycle, set by the fully pipelined dividers.
// busy is never raised in practice: the back part drains the queue every cycle.
// Asynchronous active-low reset empties the queue and the divider pipelines.
module rgb_to_hsl_converter_top import rgbhsl_pkg::*; #(
	parameter int COMP_BITS = COMP_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [IN_W-1:0]  red,
	input  logic [IN_W-1:0]  green,
	input  logic [IN_W-1:0]  blue,
	output logic             done,
	output logic [OUT_W-1:0] hue_out,
	output logic [OUT_W-1:0] sat_out,
	output logic [OUT_W-1:0] light_out
);
	localparam int DW = COMP_BITS + 4;

	logic [6*DW-1:0] fjob, bjob;
	logic            full, bvalid;

	// Classify the incoming beat.
	rgbhsl_front #(.COMP_BITS(COMP_BITS), .DW(DW)) u_front (
		.red(red), .green(green), .blue(blue), .job(fjob));

	rgbhsl_queue #(.W(6*DW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(start & ~full), .wdata(fjob),
		.full(full), .rvalid(bvalid), .rdata(bjob));

	assign busy = full;

	rgbhsl_back #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(bvalid), .job(bjob),
		.done(done), .hue_out(hue_out), .sat_out(sat_out), .light_out(light_out));
endmodule

@@ rtl/rgbhsl_front.sv @@
// Front part: finds max, min and the hue sector of a pixel.
// Produces numerator and denominator pairs for the three ratios; uses rgbhsl_pkg.
module rgbhsl_front import rgbhsl_pkg::*; #(
	parameter int COMP_BITS = COMP_BITS_DEF,
	parameter int DW = COMP_BITS + 4
) (
	input  logic [IN_W-1:0] red,
	input  logic [IN_W-1:0] green,
	input  logic [IN_W-1:0] blue,
	output logic [6*DW-1:0] job
);
	localparam logic [DW-1:0] CMAX = DW'((1 << COMP_BITS) - 1);

	logic [DW-1:0] r, g, b, mx, mn, sum, delta, six, num, hnum, sden, sden_g, hden;

	always_comb begin
		// Components are masked to the configured width.
		r = DW'(COMP_BITS'(red));
		g = DW'(COMP_BITS'(green));
		b = DW'(COMP_BITS'(blue));
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		sum = mx + mn;
		delta = mx - mn;
		six = (delta << 2) + (delta << 1);
		// Hue numerator carries one extra full turn so it never goes negative.
		if (r >= mx) begin
			num = six + g - b;
		end else if (g >= mx) begin
			num = six + (delta << 1) + b - r;
		end else begin
			num = six + (delta << 2) + r - g;
		end
		if (num >= six) num = num - six;
		sden = (sum < CMAX) ? sum : ((CMAX << 1) - sum);
		// A grey pixel divides zero by one, which rounds to zero.
		if (delta == '0) begin
			hnum = '0;
			hden = DW'(1);
			sden_g = DW'(1);
		end else begin
			hnum = num;
			hden = six;
			sden_g = sden;
		end
		job = {hnum, hden, delta, sden_g, sum, CMAX << 1};
	end
endmodule

@@ rtl/rgbhsl_queue.sv @@
// Two-entry queue between the front and back parts.
// Generic over payload width; uses rgbhsl_pkg only for the import convention.
module rgbhsl_queue import rgbhsl_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	output logic         rvalid,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         pop;

	assign full = (cnt_q == 2'd2);
	assign rvalid = (cnt_q != 2'd0);
	assign pop = rvalid;
	assign rdata = mem_q[rp_q];

	// Storage holds payload only.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// Pointers and fill count; the head leaves every cycle it is present.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ rtl/rgbhsl_div.sv @@
// Pipelined restoring divider giving round(num*(2^FRAC_BITS-1)/den), saturated.
// One quotient bit per stage; uses rgbhsl_pkg only for the import convention.
module rgbhsl_div import rgbhsl_pkg::*; #(
	parameter int DW = 12,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [DW-1:0]        num,
	input  logic [DW-1:0]        den,
	output logic                 out_valid,
	output logic [FRAC_BITS-1:0] quo
);
	localparam int QW = FRAC_BITS + 1;
	localparam int NW = DW + QW + 1;
	localparam logic [QW-1:0] OSCALE = QW'((1 << FRAC_BITS) - 1);

	logic [NW-1:0] rem_sn [QW+1];
	logic [NW-1:0] dvs_sn [QW+1];
	logic [QW-1:0] quo_sn [QW+1];
	logic          vld_sn [QW+1];
	logic [FRAC_BITS-1:0] quo_q;
	logic                 vld_q;

	// Entry stage: dividend 2*num*OSCALE + den, divisor 2*den.
	always_ff @(posedge clk) begin
		rem_sn[0] <= (NW'(num) << QW) - (NW'(num) << 1) + NW'(den);
		dvs_sn[0] <= NW'(den) << 1;
		quo_sn[0] <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sn[0] <= 1'b0;
		else vld_sn[0] <= in_valid;
	end

	// One compare and subtract per stage, most significant bit first.
	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [NW-1:0] shd;
		assign shd = dvs_sn[i] << (QW - 1 - i);
		always_ff @(posedge clk) begin
			dvs_sn[i+1] <= dvs_sn[i];
			if (rem_sn[i] >= shd) begin
				rem_sn[i+1] <= rem_sn[i] - shd;
				quo_sn[i+1] <= quo_sn[i] | (QW'(1) << (QW - 1 - i));
			end else begin
				rem_sn[i+1] <= rem_sn[i];
				quo_sn[i+1] <= quo_sn[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sn[i+1] <= 1'b0;
			else vld_sn[i+1] <= vld_sn[i];
		end
	end

	// Saturate at full scale.
	always_ff @(posedge clk) begin
		quo_q <= (quo_sn[QW] > OSCALE) ? FRAC_BITS'(OSCALE) : FRAC_BITS'(quo_sn[QW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= vld_sn[QW];
	end

	assign out_valid = vld_q;
	assign quo = quo_q;
endmodule

@@ rtl/rgbhsl_back.sv @@
// Back part: three dividers in lockstep and the result registers.
// Depends on rgbhsl_pkg and rgbhsl_div.
module rgbhsl_back import rgbhsl_pkg::*; #(
	parameter int DW = 12,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  logic [6*DW-1:0]   job,
	output logic              done,
	output logic [OUT_W-1:0]  hue_out,
	output logic [OUT_W-1:0]  sat_out,
	output logic [OUT_W-1:0]  light_out
);
	logic [FRAC_BITS-1:0] hq, sq, lq;
	logic                 hv, sv, lv;

	rgbhsl_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_hue (
		.clk(clk), .arst_n(arst_n), .in_valid(job_valid),
		.num(job[6*DW-1:5*DW]), .den(job[5*DW-1:4*DW]),
		.out_valid(hv), .quo(hq));

	rgbhsl_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_sat (
		.clk(clk), .arst_n(arst_n), .in_valid(job_valid),
		.num(job[4*DW-1:3*DW]), .den(job[3*DW-1:2*DW]),
		.out_valid(sv), .quo(sq));

	rgbhsl_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_light (
		.clk(clk), .arst_n(arst_n), .in_valid(job_valid),
		.num(job[2*DW-1:DW]), .den(job[DW-1:0]),
		.out_valid(lv), .quo(lq));

	// The three dividers run in step; the strobe follows all of them.
	assign done = hv & sv & lv;
	assign hue_out = OUT_W'(hq);
	assign sat_out = OUT_W'(sq);
	assign light_out = OUT_W'(lq);
endmodule

@@ tb/rgb_to_hsl_converter_top_tb.sv @@
// Self-checking testbench for the RGB to HSL converter.
// Drives pixels through the start/busy handshake and checks each done beat
// against an integer predictor; depends on rgbhsl_pkg and the top module.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_top_tb;
	import rgbhsl_pkg::*;

	localparam int COMP_BITS = COMP_BITS_DEF;
	localparam int FRAC_BITS = FRAC_BITS_DEF;
	localparam longint unsigned CMAX = (64'd1 << COMP_BITS) - 1;
	localparam longint unsigned OSCALE = (64'd1 << FRAC_BITS) - 1;
	localparam int LATENCY = FRAC_BITS + 5;
	localparam int N_RANDOM = 400;

	typedef struct packed {
		logic [OUT_W-1:0] hue;
		logic [OUT_W-1:0] sat;
		logic [OUT_W-1:0] light;
	} hsl_t;

	typedef struct {
		logic [IN_W-1:0] r;
		logic [IN_W-1:0] g;
		logic [IN_W-1:0] b;
		bit              typed;
		hsl_t            hsl;
	} pixel_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [IN_W-1:0]  red;
	logic [IN_W-1:0]  green;
	logic [IN_W-1:0]  blue;
	logic             done;
	logic [OUT_W-1:0] hue_out;
	logic [OUT_W-1:0] sat_out;
	logic [OUT_W-1:0] light_out;

	hsl_t       pending_hsl[$];
	int         mismatch_count = 0;
	pixel_row_t pixel_table[$];

	rgb_to_hsl_converter_top #(.COMP_BITS(COMP_BITS), .FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red(red), .green(green), .blue(blue), .done(done),
		.hue_out(hue_out), .sat_out(sat_out), .light_out(light_out)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Rounded, saturated fraction num/den scaled to the output range.
	function automatic longint unsigned scale_fraction(longint unsigned num,
			longint unsigned den);
		longint unsigned q;
		q = (2 * num * OSCALE + den) / (2 * den);
		return (q > OSCALE) ? OSCALE : q;
	endfunction

	// Hue, saturation and lightness of one pixel.
	function automatic hsl_t convert_pixel(logic [IN_W-1:0] ri, logic [IN_W-1:0] gi,
			logic [IN_W-1:0] bi);
		longint unsigned r, g, b, mx, mn, sum, delta, den, six, num;
		longint unsigned hue, sat, light;
		hsl_t res;
		r = ri & CMAX;
		g = gi & CMAX;
		b = bi & CMAX;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		sum = mx + mn;
		delta = mx - mn;
		hue = 0;
		sat = 0;
		light = scale_fraction(sum, 2 * CMAX);
		if (delta != 0) begin
			den = (sum < CMAX) ? sum : (2 * CMAX - sum);
			six = 6 * delta;
			sat = scale_fraction(delta, den);
			if (r >= mx) begin
				num = six + g - b;
			end else if (g >= mx) begin
				num = six + 2 * delta + b - r;
			end else begin
				num = six + 4 * delta + r - g;
			end
			if (num >= six) num -= six;
			hue = scale_fraction(num, six);
		end
		res.hue = hue[OUT_W-1:0];
		res.sat = sat[OUT_W-1:0];
		res.light = light[OUT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		mismatch_count++;
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic void add_row(logic [IN_W-1:0] r, logic [IN_W-1:0] g,
			logic [IN_W-1:0] b, bit typed = 0, int hu = 0, int sa = 0, int li = 0);
		pixel_row_t row;
		row.r = r;
		row.g = g;
		row.b = b;
		row.typed = typed;
		row.hsl = '{hue: hu[OUT_W-1:0], sat: sa[OUT_W-1:0], light: li[OUT_W-1:0]};
		pixel_table.push_back(row);
	endfunction

	// Result checker: every done beat is matched to the oldest expectation.
	always @(posedge clk) begin
		hsl_t want;
		if (arst_n && done) begin
			if (pending_hsl.size() == 0) begin
				mismatch_count++;
				$display("MISMATCH unexpected result beat at %0t", $realtime);
			end else begin
				want = pending_hsl.pop_front();
				if (hue_out !== want.hue) report_mismatch("hue", hue_out, want.hue);
				if (sat_out !== want.sat) report_mismatch("saturation", sat_out, want.sat);
				if (light_out !== want.light)
					report_mismatch("lightness", light_out, want.light);
			end
		end
	end

	// Send one pixel beat and record its expected result.
	task automatic send_pixel(input logic [IN_W-1:0] r, input logic [IN_W-1:0] g,
			input logic [IN_W-1:0] b, input hsl_t want);
		start <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (busy);
		pending_hsl.push_back(want);
	endtask

	// Random gap between bursts; the caller's next drive replaces start.
	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			red <= $urandom;
			green <= $urandom;
			blue <= $urandom;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stimulus.
	initial begin
		int burst;
		int gap_max;
		logic [IN_W-1:0] r, g, b;
		start = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: extremes, greys, each dominant component and ties.
		add_row(8'd0, 8'd0, 8'd0, 1, 0, 0, 0);
		add_row(8'd255, 8'd255, 8'd255, 1, 0, 0, 65535);
		add_row(8'd255, 8'd0, 8'd0, 1, 0, 65535, 32768);
		add_row(8'd0, 8'd255, 8'd0, 1, 21845, 65535, 32768);
		add_row(8'd0, 8'd0, 8'd255, 1, 43690, 65535, 32768);
		add_row(8'd128, 8'd128, 8'd128);
		add_row(8'd255, 8'd255, 8'd0);
		add_row(8'd0, 8'd255, 8'd255);
		add_row(8'd255, 8'd0, 8'd255);
		add_row(8'd255, 8'd0, 8'd1);
		add_row(8'd255, 8'd1, 8'd0);
		add_row(8'd1, 8'd0, 8'd0);
		add_row(8'd0, 8'd1, 8'd0);
		add_row(8'd0, 8'd0, 8'd1);
		add_row(8'd254, 8'd255, 8'd254);
		add_row(8'd127, 8'd128, 8'd127);
		add_row(8'd128, 8'd127, 8'd127);
		add_row(8'd100, 8'd50, 8'd200);
		add_row(8'd200, 8'd100, 8'd150);
		add_row(8'd170, 8'd85, 8'd85);
		add_row(8'd85, 8'd85, 8'd170);

		foreach (pixel_table[i]) begin
			send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b,
				pixel_table[i].typed ? pixel_table[i].hsl
				: convert_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b));
			if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 3));
		end

		// Random pixels in bursts; some phases run back to back.
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 20);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				r = $urandom;
				g = $urandom;
				b = $urandom;
				case ($urandom_range(0, 7))
					0: g = r;
					1: b = r;
					2: begin g = r; b = r; end
					3: b = g;
					default: ;
				endcase
				send_pixel(r, g, b, convert_pixel(r, g, b));
			end
			idle_gap($urandom_range(0, gap_max));
		end
		start <= 1'b0;

		// Drain the pipeline, then allow a few extra cycles for stray beats.
		for (int w = 0; w < 50 * LATENCY && pending_hsl.size() != 0; w++)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatch_count == 0 && pending_hsl.size() == 0) begin
			$display("status: pass");
		end else begin
			if (pending_hsl.size() != 0)
				$display("MISMATCH %0d results never arrived", pending_hsl.size());
			$display("status: fail");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rgbhsl_pkg.sv
rtl/rgbhsl_front.sv
rtl/rgbhsl_queue.sv
rtl/rgbhsl_div.sv
rtl/rgbhsl_back.sv
rtl/rgb_to_hsl_converter_top.sv
tb/rgb_to_hsl_converter_top_tb.sv
